FILE: sv/sart_pkg.sv
// ----------------------------------------------------------------------------
// sart_pkg
// Shared types, constants and helpers of the subnet announce round tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package sart_pkg;

  localparam int unsigned PEERS_DEF  = 4;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned ADDR_BYTES = ADDR_W / 8;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned NBYTES_W   = 4;
  localparam int unsigned APB_AW     = 6;
  localparam int unsigned APB_DW     = 64;

  localparam logic [CNT_W-1:0]    OWN_SUBNETS_RST = 8'd1;
  localparam logic [NBYTES_W-1:0] ADDR_BYTES_RST  = 4'd8;
  localparam logic [CNT_W-1:0]    ANN_ROUNDS_RST  = 8'd3;

  typedef enum logic [2:0] {
    REG_OWN_SUBNETS,
    REG_OWN_ADDR,
    REG_ADDR_BYTES,
    REG_ANN_ROUNDS,
    REG_KEEP_HW
  } reg_idx_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_ANNOUNCE,
    ACT_DONE
  } action_e;

  typedef struct packed {
    logic [CNT_W-1:0]    own_subnets;
    logic [ADDR_W-1:0]   own_addr;
    logic [NBYTES_W-1:0] addr_bytes;
    logic [CNT_W-1:0]    ann_rounds;
    logic                keep_hw;
  } cfg_t;

  typedef struct packed {
    logic load;  // latch the accepted word
    logic exec;  // update state and write the result register
  } cmd_t;

  // Mask of the significant leading bytes; zero counts as one, above eight as eight.
  function automatic logic [ADDR_W-1:0] addr_mask(input logic [NBYTES_W-1:0] nbytes);
    logic [NBYTES_W-1:0] n;
    logic [ADDR_W-1:0]   m;
    n = nbytes;
    if (n == '0) n = NBYTES_W'(1);
    if (n > NBYTES_W'(ADDR_BYTES)) n = NBYTES_W'(ADDR_BYTES);
    for (int k = 0; k < ADDR_BYTES; k++) begin
      m[ADDR_W-1-8*k -: 8] = (NBYTES_W'(k) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sart_if.sv
// ----------------------------------------------------------------------------
// sart_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface sart_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [sart_pkg::ADDR_W-1:0]   sender_address;
  logic                          address_ok;
  logic [sart_pkg::CNT_W-1:0]    peer_subnets;

  modport source (output valid, kind, sender_address, address_ok, peer_subnets,
                  input ready);
  modport sink   (input valid, kind, sender_address, address_ok, peer_subnets,
                  output ready);
endinterface

interface sart_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [sart_pkg::CNT_W-1:0] announce_count;
  logic [sart_pkg::CNT_W-1:0] total_subnets;
  logic [sart_pkg::CNT_W-1:0] start_index;

  modport source (output valid, action, announce_count, total_subnets, start_index,
                  input ready);
  modport sink   (input valid, action, announce_count, total_subnets, start_index,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/sart_regs.sv
// ----------------------------------------------------------------------------
// sart_regs
// APB configuration registers, 64-bit data, register i at byte address 8*i.
// ----------------------------------------------------------------------------
`default_nettype none

module sart_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sart_pkg::APB_AW-1:0]   paddr,
  input  wire logic [sart_pkg::APB_DW-1:0]   pwdata,
  output logic      [sart_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  output sart_pkg::cfg_t                     cfg_o
);

  sart_pkg::cfg_t     cfg_q;
  sart_pkg::reg_idx_e idx;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = sart_pkg::reg_idx_e'(paddr[sart_pkg::APB_AW-1:3]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_subnets <= sart_pkg::OWN_SUBNETS_RST;
      cfg_q.own_addr    <= '0;
      cfg_q.addr_bytes  <= sart_pkg::ADDR_BYTES_RST;
      cfg_q.ann_rounds  <= sart_pkg::ANN_ROUNDS_RST;
      cfg_q.keep_hw     <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        sart_pkg::REG_OWN_SUBNETS: cfg_q.own_subnets <= pwdata[sart_pkg::CNT_W-1:0];
        sart_pkg::REG_OWN_ADDR:    cfg_q.own_addr    <= pwdata[sart_pkg::ADDR_W-1:0];
        sart_pkg::REG_ADDR_BYTES:  cfg_q.addr_bytes  <= pwdata[sart_pkg::NBYTES_W-1:0];
        sart_pkg::REG_ANN_ROUNDS:  cfg_q.ann_rounds  <= pwdata[sart_pkg::CNT_W-1:0];
        sart_pkg::REG_KEEP_HW:     cfg_q.keep_hw     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      sart_pkg::REG_OWN_SUBNETS: prdata = sart_pkg::APB_DW'(cfg_q.own_subnets);
      sart_pkg::REG_OWN_ADDR:    prdata = sart_pkg::APB_DW'(cfg_q.own_addr);
      sart_pkg::REG_ADDR_BYTES:  prdata = sart_pkg::APB_DW'(cfg_q.addr_bytes);
      sart_pkg::REG_ANN_ROUNDS:  prdata = sart_pkg::APB_DW'(cfg_q.ann_rounds);
      sart_pkg::REG_KEEP_HW:     prdata = sart_pkg::APB_DW'(cfg_q.keep_hw);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/sart_ctrl.sv
// ----------------------------------------------------------------------------
// sart_ctrl
// Sequencer: latch a word, run the update, hand the result downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module sart_ctrl (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output sart_pkg::cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  // The result register frees up in the same cycle it is drained.
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.load  = in_valid_i && (state_q == S_IDLE);
    cmd_o.exec  = (state_q == S_EXEC) && slot_free;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        if (slot_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sart_dp.sv
// ----------------------------------------------------------------------------
// sart_dp
// Peer table, round counters, high-water mark and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sart_dp #(
  parameter int unsigned Peers = sart_pkg::PEERS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sart_pkg::cmd_t              cmd_i,
  input  wire sart_pkg::cfg_t              cfg_i,
  input  wire logic                        kind_i,
  input  wire logic [sart_pkg::ADDR_W-1:0] sender_address_i,
  input  wire logic                        address_ok_i,
  input  wire logic [sart_pkg::CNT_W-1:0]  peer_subnets_i,
  output logic      [1:0]                  action_o,
  output logic      [sart_pkg::CNT_W-1:0]  announce_count_o,
  output logic      [sart_pkg::CNT_W-1:0]  total_subnets_o,
  output logic      [sart_pkg::CNT_W-1:0]  start_index_o
);

  localparam int unsigned AW = sart_pkg::ADDR_W;
  localparam int unsigned CW = sart_pkg::CNT_W;

  // Latched word
  logic          kind_q;
  logic [AW-1:0] sender_q;
  logic          addr_ok_q;
  logic [CW-1:0] count_q;

  // Round state
  logic [Peers-1:0] peer_valid_q, peer_valid_d;
  logic [AW-1:0]    peer_addr_q [Peers];
  logic [CW-1:0]    total_q, total_d;
  logic [CW-1:0]    offset_q, offset_d;
  logic [CW-1:0]    rounds_q, rounds_d;
  logic [CW-1:0]    saved_total_q, saved_total_d;
  logic [CW-1:0]    saved_offset_q, saved_offset_d;

  // Result register
  sart_pkg::action_e action_q, action_d;
  logic [CW-1:0]     acount_q, acount_d;
  logic [CW-1:0]     rtotal_q, rtotal_d;
  logic [CW-1:0]     rstart_q, rstart_d;

  logic [AW-1:0]    mask, sender_m, own_m;
  logic [Peers-1:0] free_sel, wr_en;
  logic             dup, found;

  assign mask     = sart_pkg::addr_mask(cfg_i.addr_bytes);
  assign sender_m = sender_q & mask;
  assign own_m    = cfg_i.own_addr & mask;

  // Match every valid entry in parallel; pick the highest free entry.
  always_comb begin
    dup      = 1'b0;
    found    = 1'b0;
    free_sel = '0;
    for (int i = Peers - 1; i >= 0; i--) begin
      if (!peer_valid_q[i]) begin
        free_sel[i] = !found;
        found       = 1'b1;
      end else if ((peer_addr_q[i] & mask) == sender_m) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    peer_valid_d   = peer_valid_q;
    total_d        = total_q;
    offset_d       = offset_q;
    rounds_d       = rounds_q;
    saved_total_d  = saved_total_q;
    saved_offset_d = saved_offset_q;
    wr_en          = '0;
    action_d       = sart_pkg::ACT_NONE;
    acount_d       = '0;
    rtotal_d       = '0;
    rstart_d       = '0;

    if (!kind_q) begin
      if (addr_ok_q && !dup) begin
        wr_en        = free_sel;
        peer_valid_d = peer_valid_q | free_sel;
        if (sender_m != own_m) begin
          total_d = total_q + count_q;
          if (sender_m < own_m) offset_d = offset_q + count_q;
        end
      end
    end else if (rounds_q != '0) begin
      rounds_d = rounds_q - CW'(1);
      action_d = sart_pkg::ACT_ANNOUNCE;
      acount_d = cfg_i.own_subnets;
    end else begin
      action_d = sart_pkg::ACT_DONE;
      rtotal_d = total_q;
      rstart_d = offset_q;
      if (cfg_i.keep_hw) begin
        if (total_q < saved_total_q) begin
          rtotal_d = saved_total_q;
          rstart_d = saved_offset_q;
        end else begin
          saved_total_d  = total_q;
          saved_offset_d = offset_q;
        end
      end
      // Open a new round
      peer_valid_d = '0;
      total_d      = cfg_i.own_subnets;
      offset_d     = '0;
      rounds_d     = cfg_i.ann_rounds;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= kind_i;
      sender_q  <= sender_address_i;
      addr_ok_q <= address_ok_i;
      count_q   <= peer_subnets_i;
    end
    if (cmd_i.exec) begin
      action_q <= action_d;
      acount_q <= acount_d;
      rtotal_q <= rtotal_d;
      rstart_q <= rstart_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Peers; i++) begin
      if (cmd_i.exec && wr_en[i]) peer_addr_q[i] <= sender_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_valid_q   <= '0;
      total_q        <= sart_pkg::OWN_SUBNETS_RST;
      offset_q       <= '0;
      rounds_q       <= sart_pkg::ANN_ROUNDS_RST;
      saved_total_q  <= '0;
      saved_offset_q <= '0;
    end else if (cmd_i.exec) begin
      peer_valid_q   <= peer_valid_d;
      total_q        <= total_d;
      offset_q       <= offset_d;
      rounds_q       <= rounds_d;
      saved_total_q  <= saved_total_d;
      saved_offset_q <= saved_offset_d;
    end
  end

  assign action_o         = action_q;
  assign announce_count_o = acount_q;
  assign total_subnets_o  = rtotal_q;
  assign start_index_o    = rstart_q;

endmodule

`default_nettype wire

FILE: sv/subnet_announce_round_tracker.sv
// ----------------------------------------------------------------------------
// subnet_announce_round_tracker
// Tracks peer subnet announcements and round timeouts on the upstream link.
// ----------------------------------------------------------------------------
// Flow: an accepted word is latched, then the update on the peer table and counters
//   writes the result register (held off while the result register is stalled);
//   no new word is accepted until that update has been done.
// Reset: configuration and round registers return to their defaults, the peer table
//   is empty at once (valid bits cleared), no clearing pass.
`default_nettype none

module subnet_announce_round_tracker #(
  parameter int unsigned PEERS = sart_pkg::PEERS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  sart_in_if.sink                          in_i,
  sart_out_if.source                       out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sart_pkg::APB_AW-1:0] paddr,
  input  wire logic [sart_pkg::APB_DW-1:0] pwdata,
  output logic      [sart_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);

  sart_pkg::cfg_t cfg;
  sart_pkg::cmd_t cmd;

  sart_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sart_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  sart_dp #(
    .Peers (PEERS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg),
    .kind_i           (in_i.kind),
    .sender_address_i (in_i.sender_address),
    .address_ok_i     (in_i.address_ok),
    .peer_subnets_i   (in_i.peer_subnets),
    .action_o         (out_o.action),
    .announce_count_o (out_o.announce_count),
    .total_subnets_o  (out_o.total_subnets),
    .start_index_o    (out_o.start_index)
  );

  // A result only appears after an update cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.exec))
    else $error("result valid without an update cycle");

  // One word at a time: no accept right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("word accepted while one is in flight");

  // An announcement word yields an all-zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.action == sart_pkg::ACT_NONE) |->
      (out_o.announce_count == '0 && out_o.total_subnets == '0 &&
       out_o.start_index == '0))
    else $error("nonzero fields on an empty result");

  // A send request carries no round result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.action == sart_pkg::ACT_ANNOUNCE) |->
      (out_o.total_subnets == '0 && out_o.start_index == '0))
    else $error("round fields set on a send request");

endmodule

`default_nettype wire
